// ===== rtl/u8u16_pkg.sv =====
// ----------------------------------------------------------------------------
// u8u16_pkg
// Shared types and constants of the UTF-8 to UTF-16 decoder.
// ----------------------------------------------------------------------------
package u8u16_pkg;

  // Most code units that one input byte can cause
  localparam int unsigned MAX_UNITS = 4;
  localparam int unsigned CNT_W     = $clog2(MAX_UNITS + 1);
  localparam int unsigned IDX_W     = $clog2(MAX_UNITS);

  localparam logic [15:0] REPLACEMENT  = 16'hFFFD;

  localparam logic [7:0]  ASCII_MAX    = 8'h7F;
  localparam logic [7:0]  LEAD2_MIN    = 8'hC2;
  localparam logic [7:0]  LEAD2_MAX    = 8'hDF;
  localparam logic [7:0]  LEAD3_MIN    = 8'hE0;
  localparam logic [7:0]  LEAD3_MAX    = 8'hEF;
  localparam logic [7:0]  LEAD4_MIN    = 8'hF0;
  localparam logic [7:0]  LEAD4_MAX    = 8'hF4;

  localparam logic [20:0] MIN_CP3      = 21'h000800;
  localparam logic [20:0] MIN_CP4      = 21'h010000;
  localparam logic [20:0] MAX_CP       = 21'h10FFFF;
  localparam logic [20:0] BMP_MAX      = 21'h00FFFF;
  localparam logic [20:0] SURR_MIN     = 21'h00D800;
  localparam logic [20:0] SURR_MAX     = 21'h00DFFF;

  localparam logic [15:0] HI_SURR_BASE = 16'hD800;
  localparam logic [15:0] HI_SURR_LAST = 16'hDBFF;
  localparam logic [15:0] LO_SURR_BASE = 16'hDC00;
  localparam logic [15:0] LO_SURR_LAST = 16'hDFFF;

  // Open sequence: continuation bytes expected, bytes taken, bits so far
  typedef struct packed {
    logic [1:0]  seq_len;
    logic [1:0]  taken;
    logic [20:0] acc;
  } dec_state_t;

  // Code units caused by one byte, in order, and how many are valid
  typedef struct packed {
    logic [MAX_UNITS-1:0][15:0] units;
    logic [CNT_W-1:0]           count;
  } unit_group_t;

endpackage

// ===== rtl/utf8_to_utf16_decoder_unit.sv =====
// ----------------------------------------------------------------------------
// utf8_to_utf16_decoder_unit
// Streaming UTF-8 to UTF-16 decoder, one byte per input transaction.
// ----------------------------------------------------------------------------
// Input channel: in_valid / in_stall carry one byte (in_byte) and a flag
// (in_end_of_text) that marks the last byte of a text. Output channel:
// out_valid / out_stall carry one UTF-16 code unit (out_code_unit) and
// out_last_of_run, set on the last code unit caused by one input byte.
// A byte that only extends an open sequence causes no output transaction.
// An accepted byte lands in the input register, is decoded into the result
// buffer once that buffer is free, and its code units are offered from there.
// Throughput: one byte per cycle while each byte yields at most one code
// unit and the receiver does not stall; a byte that yields several code units
// holds the output port while the result buffer drains one unit per cycle.
// When the receiver stalls, the current code unit holds; one more byte is
// taken into the input register, then in_stall rises until the buffer frees.
// Reset clears the open sequence and drops all pending transactions.
// ----------------------------------------------------------------------------
module utf8_to_utf16_decoder_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte,
  input  logic        in_end_of_text,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_code_unit,
  output logic        out_last_of_run
);

  logic                              in_vld_r;
  logic                              in_vld_nxt;
  logic [7:0]                        byte_r;
  logic                              eot_r;
  u8u16_pkg::dec_state_t             st_r;
  u8u16_pkg::dec_state_t             st_nxt;
  u8u16_pkg::dec_state_t             dec_st;
  u8u16_pkg::unit_group_t            dec_grp;
  logic [u8u16_pkg::MAX_UNITS-1:0][15:0] units_r;
  logic [u8u16_pkg::CNT_W-1:0]       cnt_r;
  logic [u8u16_pkg::CNT_W-1:0]       cnt_nxt;
  logic [u8u16_pkg::IDX_W-1:0]       rd_r;
  logic [u8u16_pkg::IDX_W-1:0]       rd_nxt;
  logic                              in_take;
  logic                              out_take;
  logic                              buf_free;
  logic                              consume;

  u8u16_decode u_decode (
    .byte_i (byte_r),
    .eot_i  (eot_r),
    .st_i   (st_r),
    .st_o   (dec_st),
    .grp_o  (dec_grp)
  );

  assign out_valid       = (cnt_r != '0);
  assign out_code_unit   = units_r[rd_r];
  assign out_last_of_run = (cnt_r == u8u16_pkg::CNT_W'(1));
  assign out_take        = out_valid && !out_stall;
  // The buffer may be reloaded when empty or when its last unit leaves now
  assign buf_free        = !out_valid || (out_last_of_run && !out_stall);
  assign consume         = in_vld_r && buf_free;
  assign in_stall        = in_vld_r && !buf_free;
  assign in_take         = in_valid && !in_stall;

  always_comb begin
    in_vld_nxt = in_vld_r;
    if (in_take) begin
      in_vld_nxt = 1'b1;
    end else if (consume) begin
      in_vld_nxt = 1'b0;
    end
  end

  always_comb begin
    cnt_nxt = cnt_r;
    rd_nxt  = rd_r;
    st_nxt  = st_r;
    if (consume) begin
      cnt_nxt = dec_grp.count;
      rd_nxt  = '0;
      st_nxt  = dec_st;
    end else if (out_take) begin
      cnt_nxt = cnt_r - u8u16_pkg::CNT_W'(1);
      rd_nxt  = rd_r + u8u16_pkg::IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
      cnt_r    <= '0;
      rd_r     <= '0;
      st_r     <= '0;
    end else begin
      in_vld_r <= in_vld_nxt;
      cnt_r    <= cnt_nxt;
      rd_r     <= rd_nxt;
      st_r     <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      byte_r <= in_byte;
      eot_r  <= in_end_of_text;
    end
    if (consume) begin
      units_r <= dec_grp.units;
    end
  end

endmodule

// ===== rtl/u8u16_decode.sv =====
// ----------------------------------------------------------------------------
// u8u16_decode
// Decodes one UTF-8 byte against the open sequence state into a group of
// UTF-16 code units and the next sequence state.
// ----------------------------------------------------------------------------
module u8u16_decode (
  input  logic [7:0]             byte_i,
  input  logic                   eot_i,
  input  u8u16_pkg::dec_state_t  st_i,
  output u8u16_pkg::dec_state_t  st_o,
  output u8u16_pkg::unit_group_t grp_o
);

  logic                     is_cont;
  logic                     seq_open;
  logic [2:0]               taken;
  logic [20:0]              cp;
  logic                     complete;
  logic                     bad;
  logic [20:0]              v;
  logic                     is_ascii;
  logic                     lead2;
  logic                     lead3;
  logic                     lead4;
  logic                     opens;
  logic                     lead_has;
  logic [15:0]              lead_unit;
  u8u16_pkg::dec_state_t    lead_st;
  logic [u8u16_pkg::IDX_W-1:0] pre;

  assign is_cont  = (byte_i[7:6] == 2'b10);
  assign seq_open = (st_i.seq_len != 2'd0);
  assign taken    = {1'b0, st_i.taken} + 3'd1;
  assign cp       = {st_i.acc[14:0], byte_i[5:0]};
  assign complete = (taken == ({1'b0, st_i.seq_len} + 3'd1));
  assign bad      = ((taken == 3'd3) && (cp < u8u16_pkg::MIN_CP3))
                 || ((taken == 3'd4) && (cp < u8u16_pkg::MIN_CP4))
                 || (cp > u8u16_pkg::MAX_CP)
                 || ((cp >= u8u16_pkg::SURR_MIN) && (cp <= u8u16_pkg::SURR_MAX));
  assign v        = cp - u8u16_pkg::MIN_CP4;

  assign is_ascii = (byte_i <= u8u16_pkg::ASCII_MAX);
  assign lead2    = (byte_i >= u8u16_pkg::LEAD2_MIN) && (byte_i <= u8u16_pkg::LEAD2_MAX);
  assign lead3    = (byte_i >= u8u16_pkg::LEAD3_MIN) && (byte_i <= u8u16_pkg::LEAD3_MAX);
  assign lead4    = (byte_i >= u8u16_pkg::LEAD4_MIN) && (byte_i <= u8u16_pkg::LEAD4_MAX);
  assign opens    = lead2 | lead3 | lead4;
  // A lead that opens a sequence on the last byte is truncated at once
  assign lead_has  = !opens || eot_i;
  assign lead_unit = is_ascii ? {8'h00, byte_i} : u8u16_pkg::REPLACEMENT;

  always_comb begin
    lead_st = '0;
    if (opens && !eot_i) begin
      lead_st.taken = 2'd1;
      if (lead2) begin
        lead_st.seq_len = 2'd1;
        lead_st.acc     = {16'd0, byte_i[4:0]};
      end else if (lead3) begin
        lead_st.seq_len = 2'd2;
        lead_st.acc     = {17'd0, byte_i[3:0]};
      end else begin
        lead_st.seq_len = 2'd3;
        lead_st.acc     = {18'd0, byte_i[2:0]};
      end
    end
  end

  always_comb begin
    grp_o.units = {u8u16_pkg::MAX_UNITS{u8u16_pkg::REPLACEMENT}};
    grp_o.count = '0;
    st_o        = '0;
    pre         = '0;
    if (seq_open && is_cont) begin
      if (complete) begin
        if (bad) begin
          grp_o.count = taken;
        end else if (cp <= u8u16_pkg::BMP_MAX) begin
          grp_o.units[0] = cp[15:0];
          grp_o.count    = 3'd1;
        end else begin
          grp_o.units[0] = u8u16_pkg::HI_SURR_BASE + {6'd0, v[19:10]};
          grp_o.units[1] = u8u16_pkg::LO_SURR_BASE + {6'd0, v[9:0]};
          grp_o.count    = 3'd2;
        end
      end else if (eot_i) begin
        grp_o.count = taken;
      end else begin
        st_o.seq_len = st_i.seq_len;
        st_o.taken   = taken[1:0];
        st_o.acc     = cp;
      end
    end else begin
      // Replace every byte of a broken sequence, then treat this byte as a lead
      pre = seq_open ? st_i.taken : 2'd0;
      grp_o.units[pre] = lead_unit;
      grp_o.count      = {1'b0, pre} + {2'b00, lead_has};
      st_o             = lead_st;
    end
  end

endmodule

// ===== rtl/u8u16_checker.sv =====
// ----------------------------------------------------------------------------
// u8u16_checker
// Port-level checks of the UTF-8 to UTF-16 decoder, bound to the top level.
// ----------------------------------------------------------------------------
module u8u16_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic [15:0] out_code_unit,
  input logic        out_last_of_run
);

  logic hi_surr;
  logic lo_surr;

  assign hi_surr = (out_code_unit >= u8u16_pkg::HI_SURR_BASE)
                && (out_code_unit <= u8u16_pkg::HI_SURR_LAST);
  assign lo_surr = (out_code_unit >= u8u16_pkg::LO_SURR_BASE)
                && (out_code_unit <= u8u16_pkg::LO_SURR_LAST);

  // Stalled output transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_code_unit)
                               && $stable(out_last_of_run))
    else $error("stalled output transaction changed");

  // No output transaction right after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid right after reset");

  // A high surrogate is never last and is followed at once by a low one
  a_pair: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && hi_surr |-> !out_last_of_run ##1 out_valid && lo_surr)
    else $error("high surrogate not followed by low surrogate");

  // A low surrogate closes the run of its byte
  a_lo_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && lo_surr |-> out_last_of_run)
    else $error("low surrogate not last of run");

  // An ASCII unit always closes the run of its byte
  a_ascii_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_code_unit[15:7] == 9'd0) |-> out_last_of_run)
    else $error("ASCII unit not last of run");

endmodule

bind utf8_to_utf16_decoder_unit u8u16_checker u_u8u16_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_code_unit   (out_code_unit),
  .out_last_of_run (out_last_of_run)
);
